// ----- sv/sfr_pkg.sv -----
// Shared types, codes and constants for the stuffed frame receiver.
package sfr_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 512;
  localparam int unsigned QUEUE_DEPTH         = 2;
  localparam int unsigned BYTE_W              = 8;
  localparam int unsigned INDEX_W             = 9;
  localparam int unsigned STATUS_W            = 2;
  localparam int unsigned CFG_INDEX_W         = 2;

  localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;
  localparam logic [BYTE_W-1:0] MASK_RESET   = 8'd32;
  localparam logic [BYTE_W:0]   MOD_SUM      = 9'd255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FLAG   = 2'd0,
    CFG_ESCAPE = 2'd1,
    CFG_MASK   = 2'd2
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NORMAL     = 2'd0,
    ST_FLAG       = 2'd1,
    ST_NO_STORAGE = 2'd2,
    ST_CORRUPT    = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] delim_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] xor_mask;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              is_flag;
    logic              is_escape;
  } item_t;

  // mod-255 add of two values each below 256; result below 255 when at least one value is below 255
  function automatic logic [BYTE_W-1:0] add_mod255(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MOD_SUM) s = s - MOD_SUM;
    return s[BYTE_W-1:0];
  endfunction

endpackage

// ----- sv/sfr_front.sv -----
// Front end: takes input beats and tags flag and escape bytes.
module sfr_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sfr_pkg::BYTE_W-1:0]   in_rx_byte,
  input  sfr_pkg::cfg_t                cfg,
  input  logic                         q_full,
  output logic                         q_push,
  output sfr_pkg::item_t               q_item
);

  assign in_stall          = q_full;
  assign q_push            = in_valid && !q_full;
  assign q_item.rx_byte    = in_rx_byte;
  assign q_item.is_flag    = (in_rx_byte == cfg.delim_byte);
  assign q_item.is_escape  = (in_rx_byte == cfg.escape_byte);

endmodule

// ----- sv/sfr_queue.sv -----
// Short queue between the front end and the frame engine.
module sfr_queue #(
  parameter int unsigned DEPTH = sfr_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sfr_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output sfr_pkg::item_t pop_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sfr_pkg::item_t entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- sv/sfr_back.sv -----
// Frame engine: un-stuffing, byte positions, running sums and frame check.
module sfr_back #(
  parameter int unsigned MAX_FRAME_BYTES = sfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfr_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  sfr_pkg::item_t                q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sfr_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_stored_valid,
  output logic [sfr_pkg::BYTE_W-1:0]    out_stored_byte,
  output logic [sfr_pkg::INDEX_W-1:0]   out_stored_index,
  output logic                          out_frame_done,
  output logic                          out_frame_good
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned KW    = (CNT_W > sfr_pkg::INDEX_W) ? CNT_W : sfr_pkg::INDEX_W;

  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          esc_r, esc_nxt;
  logic [sfr_pkg::BYTE_W-1:0]    len_r, len_nxt;
  logic [sfr_pkg::BYTE_W-1:0]    sum1_r, sum1_nxt;
  logic [sfr_pkg::BYTE_W-1:0]    sum2_r, sum2_nxt;
  logic                          pass_r, pass_nxt;

  logic                          ov_r;
  sfr_pkg::status_t              st_r, st_c;
  logic                          sv_r, sv_c;
  logic [sfr_pkg::BYTE_W-1:0]    sb_r, sb_c;
  logic [sfr_pkg::INDEX_W-1:0]   si_r, si_c;
  logic                          fd_r, fd_c;
  logic                          fg_r, fg_c;

  logic [KW-1:0]                 idx_k, len_k;
  logic [sfr_pkg::BYTE_W-1:0]    len_eff;

  assign q_pop = q_valid && (!ov_r || !out_stall);

  always_comb begin
    cnt_nxt  = cnt_r;
    esc_nxt  = esc_r;
    len_nxt  = len_r;
    sum1_nxt = sum1_r;
    sum2_nxt = sum2_r;
    pass_nxt = pass_r;
    st_c     = sfr_pkg::ST_NORMAL;
    sv_c     = 1'b0;
    sb_c     = '0;
    si_c     = '0;
    fd_c     = 1'b0;
    fg_c     = 1'b0;
    idx_k    = KW'(cnt_r);
    len_eff  = len_r;
    len_k    = '0;

    if (cnt_r >= CNT_W'(MAX_FRAME_BYTES)) begin
      st_c = sfr_pkg::ST_NO_STORAGE;
    end else if (q_item.is_flag) begin
      st_c = sfr_pkg::ST_FLAG;
      sv_c = 1'b1;
      sb_c = q_item.rx_byte;
    end else if (cnt_r < CNT_W'(2)) begin
      st_c = sfr_pkg::ST_CORRUPT;
    end else if (q_item.is_escape) begin
      esc_nxt = 1'b1;
    end else if (esc_r) begin
      sv_c    = 1'b1;
      sb_c    = q_item.rx_byte ^ cfg.xor_mask;
      esc_nxt = 1'b0;
    end else begin
      sv_c = 1'b1;
      sb_c = q_item.rx_byte;
    end

    if (sv_c) begin
      si_c    = idx_k[sfr_pkg::INDEX_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (idx_k == KW'(3)) len_eff = sb_c;
      len_nxt = len_eff;
      len_k   = KW'(len_eff);
      if (idx_k < len_k + KW'(4)) begin
        sum1_nxt = sfr_pkg::add_mod255(sum1_r, sb_c);
        sum2_nxt = sfr_pkg::add_mod255(sum2_r, sum1_nxt);
      end else if (idx_k == len_k + KW'(4)) begin
        if (sb_c != sum1_r) pass_nxt = 1'b0;
      end else if (idx_k == len_k + KW'(5)) begin
        if (sb_c != sum2_r) pass_nxt = 1'b0;
      end else if (idx_k == len_k + KW'(6)) begin
        if (sb_c != cfg.delim_byte) pass_nxt = 1'b0;
      end else if (idx_k == len_k + KW'(7)) begin
        fd_c     = 1'b1;
        fg_c     = pass_r && (sb_c == cfg.delim_byte);
        cnt_nxt  = '0;
        esc_nxt  = 1'b0;
        len_nxt  = '0;
        sum1_nxt = '0;
        sum2_nxt = '0;
        pass_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      esc_r  <= 1'b0;
      len_r  <= '0;
      sum1_r <= '0;
      sum2_r <= '0;
      pass_r <= 1'b1;
      ov_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        cnt_r  <= cnt_nxt;
        esc_r  <= esc_nxt;
        len_r  <= len_nxt;
        sum1_r <= sum1_nxt;
        sum2_r <= sum2_nxt;
        pass_r <= pass_nxt;
        ov_r   <= 1'b1;
      end else if (!out_stall) begin
        ov_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      st_r <= st_c;
      sv_r <= sv_c;
      sb_r <= sb_c;
      si_r <= si_c;
      fd_r <= fd_c;
      fg_r <= fg_c;
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = st_r;
  assign out_stored_valid = sv_r;
  assign out_stored_byte  = sb_r;
  assign out_stored_index = si_r;
  assign out_frame_done   = fd_r;
  assign out_frame_good   = fg_r;

  a_done_stored: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && fd_r |-> sv_r)
    else $error("frame end without a stored byte");

  a_good_done: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && fg_r |-> fd_r)
    else $error("frame_good outside frame end");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && fd_c |=> (cnt_r == '0) && pass_r && !esc_r)
    else $error("state not restarted after frame end");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_FRAME_BYTES))
    else $error("byte count past frame limit");

  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sum1_r < 8'd255) && (sum2_r < 8'd255))
    else $error("running sum out of mod-255 range");

endmodule

// ----- sv/stuffed_frame_receiver.sv -----
// Top level of the stuffed frame receiver: config registers, front end, queue, frame engine.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+--------------
//  input   | in_rx_byte                                   | in_valid/in_stall
//  result  | out_status, out_stored_*, out_frame_done/good | out_valid/out_stall
//  config  | cfg_index, cfg_data                          | cfg_valid/cfg_ready
//
//  One beat per cycle sustained while out_stall is low; a result passes through the queue
//  entry register, then the frame engine's output register.
//  The queue holds two beats; in_stall rises only while it is full.
//  out_stall holds the output register and, once the queue fills, the input.
//  Synchronous active-low reset; config writes are always ready.
module stuffed_frame_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = sfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sfr_pkg::BYTE_W-1:0]      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sfr_pkg::STATUS_W-1:0]    out_status,
  output logic                            out_stored_valid,
  output logic [sfr_pkg::BYTE_W-1:0]      out_stored_byte,
  output logic [sfr_pkg::INDEX_W-1:0]     out_stored_index,
  output logic                            out_frame_done,
  output logic                            out_frame_good,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfr_pkg::BYTE_W-1:0]      cfg_data
);

  sfr_pkg::cfg_t  cfg_r;
  logic           q_full, q_push, q_pop, q_valid;
  sfr_pkg::item_t push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delim_byte  <= sfr_pkg::FLAG_RESET;
      cfg_r.escape_byte <= sfr_pkg::ESCAPE_RESET;
      cfg_r.xor_mask    <= sfr_pkg::MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfr_pkg::CFG_FLAG:   cfg_r.delim_byte  <= cfg_data;
        sfr_pkg::CFG_ESCAPE: cfg_r.escape_byte <= cfg_data;
        sfr_pkg::CFG_MASK:   cfg_r.xor_mask    <= cfg_data;
        default: ;
      endcase
    end
  end

  sfr_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  sfr_queue #(
    .DEPTH (sfr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  sfr_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_item           (pop_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_stored_valid (out_stored_valid),
    .out_stored_byte  (out_stored_byte),
    .out_stored_index (out_stored_index),
    .out_frame_done   (out_frame_done),
    .out_frame_good   (out_frame_good)
  );

endmodule
